// ===== hdl/lcg_pkg.sv =====
package lcg_pkg;

	localparam int GridW = 32;
	localparam int GridH = 32;
	localparam int IdxW = 10;
	localparam int MassW = 16;
	localparam int AccW = 20;
	localparam int StoneW = 11;
	localparam int OneQ = 4096;

	// Configuration register indexes.
	localparam logic [1:0] REG_MIN_LIQUID = 2'd0;
	localparam logic [1:0] REG_FLOW_KNEE  = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED  = 2'd2;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		T_EMPTY = 2'd0,
		T_SOLID = 2'd1,
		T_WATER = 2'd2,
		T_LAVA  = 2'd3
	} cell_kind_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [IdxW-1:0]  cell_index;
		logic [1:0]       cell_type;
		logic [MassW-1:0] cell_mass;
	} req_t;

	typedef struct packed {
		logic              result_kind;
		logic [1:0]        out_type;
		logic [MassW-1:0]  out_mass;
		logic [StoneW-1:0] stones_made;
	} rsp_t;

	// Limit one flow: halve above the flow knee, clamp to 0..hi.
	function automatic logic signed [AccW-1:0] limit_flow(
		input logic signed [AccW-1:0] f,
		input logic [MassW-1:0] knee,
		input logic signed [AccW-1:0] hi
	);
		logic signed [AccW-1:0] g;
		begin
			g = f;
			if (f > $signed({{(AccW-MassW){1'b0}}, knee})) begin
				g = (f < 0) ? -((-f) >>> 1) : (f >>> 1);
			end
			if (g < 0) g = '0;
			if (g > hi) g = hi;
			return g;
		end
	endfunction

	// Stable mass of a column pair: max(1.0, floor(m/2)), m not negative.
	function automatic logic signed [AccW-1:0] stable_of(input logic signed [AccW-1:0] m);
		logic signed [AccW-1:0] h;
		begin
			h = m >>> 1;
			return (h < AccW'(OneQ)) ? AccW'(OneQ) : h;
		end
	endfunction

endpackage

// ===== hdl/lcg_if.sv =====
interface lcg_req_if;
	import lcg_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface lcg_rsp_if;
	import lcg_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/liquid_cell_grid_step.sv =====
// Channel   Direction  Beat
// req       sink       action, cell_index, cell_type, cell_mass
// rsp       source     result_kind, out_type, out_mass, stones_made
// cfg       write      cfg_we, cfg_idx, cfg_data
// A cell write lands when it is taken; a read passes S_RD and S_OUT before its result beat.
// A step clears the new grid cell by cell, walks every cell through one shared
// flow unit, a liquid cell taking longer there than others, then commits the
// new grid cell by cell with a read and a write for each.
// After reset a clearing pass over all GRID_W*GRID_H cells empties the grid;
// no request is taken meanwhile. A waiting result holds off the next request.
module liquid_cell_grid_step #(
	parameter int GRID_W = lcg_pkg::GridW,
	parameter int GRID_H = lcg_pkg::GridH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lcg_req_if.sink                  req,
	lcg_rsp_if.source                rsp,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [lcg_pkg::MassW-1:0] cfg_data
);
	import lcg_pkg::*;

	localparam int Cells = GRID_W * GRID_H;
	localparam int AW = $clog2(Cells);
	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);

	// Flow directions, in the order they are tried.
	localparam logic [1:0] DirDown  = 2'd0;
	localparam logic [1:0] DirLeft  = 2'd1;
	localparam logic [1:0] DirRight = 2'd2;
	localparam logic [1:0] DirUp    = 2'd3;

	typedef enum logic [12:0] {
		S_CLR   = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_RD    = 13'b0000000000100,
		S_NCLR  = 13'b0000000001000,
		S_LOAD  = 13'b0000000010000,
		S_NB    = 13'b0000000100000,
		S_OWN   = 13'b0000001000000,
		S_DIR   = 13'b0000010000000,
		S_DIRW  = 13'b0000100000000,
		S_NEXT  = 13'b0001000000000,
		S_CMRD  = 13'b0010000000000,
		S_CMWR  = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Grid memories; read data registered.
	logic [1:0]       ctype_mem [Cells];
	logic [MassW-1:0] cmass_mem [Cells];
	logic [1:0]       ntype_mem [Cells];
	logic [AccW-1:0]  nmass_mem [Cells];
	logic [1:0]       ctype_rd_q, ntype_rd_q;
	logic [MassW-1:0] cmass_rd_q;
	logic [AccW-1:0]  nmass_rd_q;

	logic [MassW-1:0] min_liquid_q, flow_knee_q, max_speed_q;

	logic [AW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [2:0]    nb_q;   // neighbour step: 0..4 lava test / load
	logic [1:0]    dir_q;  // 0 down, 1 left, 2 right, 3 up
	logic [1:0]    own_q;
	logic [MassW-1:0] own_m_q;
	logic signed [AccW-1:0] rem_q;
	logic signed [AccW-1:0] self_acc_q;
	logic [3:0]    nb_ok_q;   // neighbour exists
	logic [1:0]    nb_t_q [4];
	logic [MassW-1:0] nb_m_q [4];
	logic          water_q;
	logic [StoneW-1:0] stones_q;
	logic signed [AccW-1:0] flow_q;
	logic          do_q;
	rsp_t          rsp_q;
	logic          rsp_v_q;

	// Address of neighbour d of the cell under work.
	function automatic logic [AW-1:0] nb_addr(input logic [1:0] d,
	                                          input logic [XW-1:0] x,
	                                          input logic [YW-1:0] y);
		logic [AW:0] base;
		begin
			base = (AW+1)'(y) * (AW+1)'(GRID_W) + (AW+1)'(x);
			case (d)
				DirDown:  return AW'(base - (AW+1)'(GRID_W));
				DirLeft:  return AW'(base - 1'b1);
				DirRight: return AW'(base + 1'b1);
				default:  return AW'(base + (AW+1)'(GRID_W));
			endcase
		end
	endfunction

	logic [AW-1:0] self_a;
	assign self_a = AW'((AW+1)'(y_q) * (AW+1)'(GRID_W) + (AW+1)'(x_q));

	logic [3:0] exists;
	assign exists[0] = (y_q != '0);
	assign exists[1] = (x_q != '0);
	assign exists[2] = (32'(x_q) + 1 < GRID_W);
	assign exists[3] = (32'(y_q) + 1 < GRID_H);

	// Shared flow unit: one direction per pass.
	logic signed [AccW-1:0] f_raw, f_lim, hi, nbm, ownm, lim_v;
	logic may;
	always_comb begin
		nbm  = AccW'(nb_m_q[dir_q]);
		ownm = AccW'(own_m_q);
		lim_v = (rem_q < AccW'(max_speed_q)) ? rem_q : AccW'(max_speed_q);
		may = exists[dir_q] && (nb_t_q[dir_q] == T_EMPTY || nb_t_q[dir_q] == own_q);
		case (dir_q)
			DirDown: begin
				f_raw = stable_of(rem_q + nbm) - nbm;
				hi = lim_v;
			end
			DirUp: begin
				f_raw = rem_q - stable_of(rem_q + nbm);
				hi = lim_v;
			end
			default: begin
				f_raw = (ownm > nbm) ? ((ownm - nbm) >>> 2) : '0;
				hi = rem_q;
			end
		endcase
		f_lim = limit_flow(f_raw, flow_knee_q, hi);
	end

	// Commit value of one cell.
	logic signed [AccW-1:0] cm_s;
	logic [MassW-1:0] cm_sat;
	logic [1:0] cm_t;
	logic [MassW-1:0] cm_m;
	always_comb begin
		cm_s = $signed(nmass_rd_q);
		cm_sat = (cm_s < 0) ? '0 : (cm_s > 65535) ? 16'hFFFF : cm_s[MassW-1:0];
		cm_t = ntype_rd_q;
		cm_m = cm_sat;
		if (ntype_rd_q != T_SOLID &&
		    ({4'd0, cm_sat} <= {4'd0, min_liquid_q} || ntype_rd_q == T_EMPTY)) begin
			cm_t = T_EMPTY;
			cm_m = '0;
		end
	end

	logic in_grid;
	assign in_grid = (32'(req.payload.cell_index) < Cells);
	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.payload = rsp_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_liquid_q <= 16'd4;
			flow_knee_q <= 16'd4096;
			max_speed_q <= 16'd32768;
		end else if (cfg_we) begin
			if (cfg_idx == REG_MIN_LIQUID) min_liquid_q <= cfg_data;
			if (cfg_idx == REG_FLOW_KNEE) flow_knee_q <= cfg_data;
			if (cfg_idx == REG_MAX_SPEED) max_speed_q <= cfg_data;
		end
	end

	// Memory port work, driven by the sequencer state.
	logic [AW-1:0] c_ra, n_ra, c_wa, n_wa;
	logic c_we, n_we, ct_we;
	logic [1:0] c_wt, n_wt;
	logic [MassW-1:0] c_wm;
	logic [AccW-1:0] n_wm;
	logic [1:0] ct_wt;
	always_comb begin
		c_ra = self_a; n_ra = self_a; c_wa = cnt_q; n_wa = cnt_q;
		c_we = 1'b0; n_we = 1'b0; ct_we = 1'b0;
		c_wt = T_EMPTY; c_wm = '0; n_wt = T_EMPTY; n_wm = '0; ct_wt = T_EMPTY;
		case (state_q)
			S_CLR: begin c_we = 1'b1; end
			S_IDLE: begin
				c_ra = AW'(req.payload.cell_index);
				c_wa = AW'(req.payload.cell_index);
				c_we = req.valid && req.ready && req.payload.action == ACT_WRITE && in_grid;
				c_wt = req.payload.cell_type;
				c_wm = req.payload.cell_mass;
			end
			S_NCLR: begin n_we = 1'b1; end
			S_LOAD: c_ra = self_a;
			S_NB: c_ra = nb_addr(nb_q[1:0], x_q, y_q);
			S_OWN: begin
				// An empty cell leaves whatever earlier flows put in its place.
				n_wa = self_a; n_we = (own_q != T_EMPTY);
				if (own_q == T_SOLID) begin n_wt = T_SOLID; n_wm = AccW'(OneQ); end
				else if (own_q == T_LAVA && water_q) begin
					n_wt = T_SOLID; n_wm = '0;
					ct_we = 1'b1; ct_wt = T_SOLID;
				end else begin
					n_wt = own_q; n_wm = nmass_rd_q + AccW'(own_m_q);
				end
				c_wa = self_a;
			end
			S_DIR: n_ra = nb_addr(dir_q, x_q, y_q);
			S_DIRW: begin
				n_wa = nb_addr(dir_q, x_q, y_q); n_we = do_q;
				n_wt = own_q; n_wm = nmass_rd_q + flow_q;
			end
			S_NEXT: begin
				// Only a flowing liquid cell writes back its remaining mass.
				n_wa = self_a; n_wt = own_q; n_wm = self_acc_q;
				n_we = (own_q == T_WATER) || (own_q == T_LAVA && !water_q);
			end
			S_CMRD: n_ra = cnt_q;
			S_CMWR: begin c_we = 1'b1; c_wt = cm_t; c_wm = cm_m; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (c_we) begin ctype_mem[c_wa] <= c_wt; cmass_mem[c_wa] <= c_wm; end
		else if (ct_we) ctype_mem[c_wa] <= ct_wt;
		if (n_we) begin ntype_mem[n_wa] <= n_wt; nmass_mem[n_wa] <= n_wm; end
		ctype_rd_q <= ctype_mem[c_ra];
		cmass_rd_q <= cmass_mem[c_ra];
		ntype_rd_q <= ntype_mem[n_ra];
		nmass_rd_q <= nmass_mem[n_ra];
	end

	// Sequencer. Self mass accumulates in self_acc_q; the running remainder in rem_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; cnt_q <= '0; rsp_v_q <= 1'b0;
			x_q <= '0; y_q <= '0; nb_q <= '0; dir_q <= '0; stones_q <= '0;
			do_q <= 1'b0; water_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == Cells - 1) begin cnt_q <= '0; state_q <= S_IDLE; end
				end
				S_IDLE: if (req.valid && req.ready) begin
					if (req.payload.action == ACT_READ) begin
						rsp_q <= '0;
						state_q <= in_grid ? S_RD : S_OUT;
					end else if (req.payload.action == ACT_STEP) begin
						cnt_q <= '0; stones_q <= '0; state_q <= S_NCLR;
					end
				end
				S_RD: begin
					rsp_q <= '{1'b0, ctype_rd_q, cmass_rd_q, {StoneW{1'b0}}};
					state_q <= S_OUT;
				end
				S_NCLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == Cells - 1) begin
						x_q <= '0; y_q <= YW'(GRID_H - 1); state_q <= S_LOAD;
					end
				end
				S_LOAD: begin nb_q <= '0; state_q <= S_NB; end
				S_NB: begin
					// Read data is registered: capture the data of the previous request.
					if (nb_q == 3'd0) begin own_q <= ctype_rd_q; own_m_q <= cmass_rd_q; end
					else begin
						nb_t_q[nb_q[1:0] - 2'd1] <= ctype_rd_q;
						nb_m_q[nb_q[1:0] - 2'd1] <= cmass_rd_q;
					end
					nb_q <= nb_q + 1'b1;
					if (nb_q == 3'd4) state_q <= S_OWN;
				end
				S_OWN: begin
					if (own_q == T_SOLID || own_q == T_EMPTY) state_q <= S_NEXT;
					else if (own_q == T_LAVA && water_q) begin
						if (stones_q != '1) stones_q <= stones_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						rem_q <= AccW'(own_m_q); dir_q <= DirDown;
						self_acc_q <= nmass_rd_q + AccW'(own_m_q);
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					do_q <= may && !((dir_q == DirLeft || dir_q == DirRight) && rem_q <= 0);
					flow_q <= f_lim;
					state_q <= S_DIRW;
				end
				S_DIRW: begin
					if (do_q) begin
						rem_q <= rem_q - flow_q;
						self_acc_q <= self_acc_q - flow_q;
					end
					dir_q <= dir_q + 1'b1;
					if (dir_q == DirUp || ((rem_q - (do_q ? flow_q : '0)) <= 0 && dir_q != DirRight))
						state_q <= S_NEXT;
					else state_q <= S_DIR;
				end
				S_NEXT: begin
					if (y_q == '0) begin
						y_q <= YW'(GRID_H - 1);
						if (32'(x_q) == GRID_W - 1) begin cnt_q <= '0; state_q <= S_CMRD; end
						else begin x_q <= x_q + 1'b1; state_q <= S_LOAD; end
					end else begin y_q <= y_q - 1'b1; state_q <= S_LOAD; end
				end
				S_CMRD: state_q <= S_CMWR;
				S_CMWR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == Cells - 1) begin
						rsp_q <= '{1'b1, 2'd0, {MassW{1'b0}}, stones_q};
						state_q <= S_OUT;
					end else state_q <= S_CMRD;
				end
				S_OUT: if (!rsp_v_q) begin rsp_v_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_CLR;
			endcase
			// Lava water test from neighbour types once captured.
			if (state_q == S_NB && nb_q == 3'd4)
				water_q <= (exists[0] && nb_t_q[0] == T_WATER) ||
				           (exists[1] && nb_t_q[1] == T_WATER) ||
				           (exists[2] && nb_t_q[2] == T_WATER) ||
				           (exists[3] && ctype_rd_q == T_WATER);
		end
	end

endmodule

// ===== bench/tb_liquid_cell_grid_step.sv =====
`timescale 1ns / 100ps

module tb_liquid_cell_grid_step;
	import lcg_pkg::*;

	localparam int Cells = GridW * GridH;
	localparam int HangLimit = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [MassW-1:0] cfg_data;

	lcg_req_if req_if ();
	lcg_rsp_if rsp_if ();

	liquid_cell_grid_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Mirror of the grid and the registers.
	cell_kind_t grid_kind[Cells];
	int grid_mass[Cells];
	int min_liquid_q;
	int flow_knee_q;
	int max_speed_q;

	rsp_t pending_results[$];
	int errors;
	bit gaps_on;
	bit long_hold;
	int quiet_cycles;

	// Clock and reset.
	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int stable_mass(int m);
		int h;
		h = m / 2;
		return (h < OneQ) ? OneQ : h;
	endfunction

	function automatic int clamp_flow(int f, int hi);
		int g;
		g = f;
		if (g > flow_knee_q) g = g / 2;
		if (g < 0) g = 0;
		if (g > hi) g = hi;
		return g;
	endfunction

	function automatic bit can_enter(int j, cell_kind_t own);
		return grid_kind[j] == T_EMPTY || grid_kind[j] == own;
	endfunction

	function automatic bit near_water(int x, int y);
		if (x + 1 < GridW && grid_kind[y * GridW + x + 1] == T_WATER) return 1'b1;
		if (x > 0 && grid_kind[y * GridW + x - 1] == T_WATER) return 1'b1;
		if (y + 1 < GridH && grid_kind[(y + 1) * GridW + x] == T_WATER) return 1'b1;
		if (y > 0 && grid_kind[(y - 1) * GridW + x] == T_WATER) return 1'b1;
		return 1'b0;
	endfunction

	// One flow sweep over the mirrored grid, then the commit. Returns the stone count.
	function automatic int sweep_grid();
		cell_kind_t nk[Cells];
		int nm[Cells];
		cell_kind_t own;
		int stones, x, y, i, rem, f, lim, d, m;
		stones = 0;
		for (i = 0; i < Cells; i++) begin
			nk[i] = T_EMPTY;
			nm[i] = 0;
		end
		for (x = 0; x < GridW; x++) begin
			for (y = GridH - 1; y >= 0; y--) begin
				i = y * GridW + x;
				own = grid_kind[i];
				if (own == T_SOLID) begin
					nk[i] = T_SOLID;
					nm[i] = OneQ;
					continue;
				end
				if (own == T_EMPTY) continue;
				// Lava against water sets at once and is seen as solid from here on.
				if (own == T_LAVA && near_water(x, y)) begin
					nk[i] = T_SOLID;
					nm[i] = 0;
					grid_kind[i] = T_SOLID;
					if (stones < 2047) stones++;
					continue;
				end
				rem = grid_mass[i];
				nk[i] = own;
				nm[i] += rem;
				if (y > 0 && can_enter(i - GridW, own)) begin
					lim = rem < max_speed_q ? rem : max_speed_q;
					f = clamp_flow(stable_mass(rem + grid_mass[i - GridW])
						- grid_mass[i - GridW], lim);
					nm[i] -= f;
					nm[i - GridW] += f;
					nk[i - GridW] = own;
					rem -= f;
				end
				if (rem <= 0) continue;
				if (x > 0 && can_enter(i - 1, own)) begin
					d = grid_mass[i] - grid_mass[i - 1];
					f = clamp_flow(d > 0 ? d / 4 : 0, rem);
					nm[i] -= f;
					nm[i - 1] += f;
					nk[i - 1] = own;
					rem -= f;
				end
				if (rem <= 0) continue;
				if (x + 1 < GridW && can_enter(i + 1, own)) begin
					d = grid_mass[i] - grid_mass[i + 1];
					f = clamp_flow(d > 0 ? d / 4 : 0, rem);
					nm[i] -= f;
					nm[i + 1] += f;
					nk[i + 1] = own;
					rem -= f;
				end
				if (y + 1 < GridH && can_enter(i + GridW, own)) begin
					lim = rem < max_speed_q ? rem : max_speed_q;
					f = clamp_flow(rem - stable_mass(rem + grid_mass[i + GridW]), lim);
					nm[i] -= f;
					nm[i + GridW] += f;
					nk[i + GridW] = own;
					rem -= f;
				end
			end
		end
		// Commit with saturation; thin or typeless liquid is cleared.
		for (i = 0; i < Cells; i++) begin
			m = nm[i];
			if (m < 0) m = 0;
			if (m > 65535) m = 65535;
			grid_kind[i] = nk[i];
			grid_mass[i] = m;
			if (nk[i] != T_SOLID && (m <= min_liquid_q || nk[i] == T_EMPTY)) begin
				grid_kind[i] = T_EMPTY;
				grid_mass[i] = 0;
			end
		end
		return stones;
	endfunction

	// Update the mirror for one accepted request and queue its result.
	function automatic void predict_request(req_t r);
		rsp_t e;
		e = '0;
		case (action_t'(r.action))
			ACT_WRITE: begin
				grid_kind[r.cell_index] = cell_kind_t'(r.cell_type);
				grid_mass[r.cell_index] = r.cell_mass;
			end
			ACT_STEP: begin
				e.result_kind = 1'b1;
				e.stones_made = StoneW'(sweep_grid());
				pending_results.push_back(e);
			end
			ACT_READ: begin
				e.out_type = grid_kind[r.cell_index];
				e.out_mass = MassW'(grid_mass[r.cell_index]);
				pending_results.push_back(e);
			end
			default: ;
		endcase
	endfunction

	// Offer one request beat and wait for it to be taken. Called at a rising edge.
	task automatic send_request(action_t act, int idx, cell_kind_t kind, int mass);
		req_t r;
		int gap;
		r.action = act;
		r.cell_index = IdxW'(idx);
		r.cell_type = kind;
		r.cell_mass = MassW'(mass);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predict_request(r);
	endtask

	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// Writes give no result and may still be in flight.
		repeat (12) @(posedge clk);
	endtask

	// One register write, with cfg_we dropped again before the task returns.
	task automatic write_cfg(logic [1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= MassW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_LIQUID: min_liquid_q = value;
			REG_FLOW_KNEE: flow_knee_q = value;
			default: max_speed_q = value;
		endcase
		@(posedge clk);
	endtask

	task automatic set_all_cfg(int ml, int mf, int ms);
		write_cfg(REG_MIN_LIQUID, ml);
		write_cfg(REG_FLOW_KNEE, mf);
		write_cfg(REG_MAX_SPEED, ms);
	endtask

	// Response side: random back-pressure, plus one long hold-off on request.
	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				rsp_if.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat %p", rsp_if.payload);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp_if.payload.result_kind !== e.result_kind) begin
					$error("result_kind: expected %0d, got %0d", e.result_kind,
						rsp_if.payload.result_kind);
					errors++;
				end
				if (rsp_if.payload.out_type !== e.out_type) begin
					$error("out_type: expected %0d, got %0d", e.out_type,
						rsp_if.payload.out_type);
					errors++;
				end
				if (rsp_if.payload.out_mass !== e.out_mass) begin
					$error("out_mass: expected %0d, got %0d", e.out_mass,
						rsp_if.payload.out_mass);
					errors++;
				end
				if (rsp_if.payload.stones_made !== e.stones_made) begin
					$error("stones_made: expected %0d, got %0d", e.stones_made,
						rsp_if.payload.stones_made);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HangLimit) begin
				$display("tb_liquid_cell_grid_step: done, errors");
				$finish;
			end
		end
	end

	// Extremes of every field, each action, and the named corner cases.
	task automatic test_directed();
		send_request(ACT_WRITE, 0, T_LAVA, 16'hFFFF);
		send_request(ACT_WRITE, Cells - 1, T_WATER, 16'hFFFF);
		send_request(ACT_READ, 0, T_EMPTY, 0);
		send_request(ACT_READ, Cells - 1, T_EMPTY, 0);
		// Lava touching water sets to stone.
		send_request(ACT_WRITE, 3 * GridW + 3, T_LAVA, 3000);
		send_request(ACT_WRITE, 3 * GridW + 4, T_WATER, 9000);
		// A water column over empty cells, an empty cell holding mass, a solid.
		send_request(ACT_WRITE, 5 * GridW + 10, T_WATER, 8192);
		send_request(ACT_WRITE, 5 * GridW + 11, T_EMPTY, 500);
		send_request(ACT_WRITE, 2 * GridW + 10, T_SOLID, 0);
		// Liquid against the top and left edges.
		send_request(ACT_WRITE, (GridH - 1) * GridW, T_LAVA, 3000);
		send_request(ACT_NONE, 7, T_SOLID, 1234);
		send_request(ACT_STEP, 0, T_EMPTY, 0);
		send_request(ACT_READ, 3 * GridW + 3, T_EMPTY, 0);
		send_request(ACT_READ, 4 * GridW + 10, T_EMPTY, 0);
		send_request(ACT_READ, 5 * GridW + 11, T_EMPTY, 0);
		send_request(ACT_READ, 2 * GridW + 10, T_EMPTY, 0);
		send_request(ACT_READ, (GridH - 2) * GridW, T_EMPTY, 0);
		send_request(ACT_READ, 7, T_EMPTY, 0);
		send_request(ACT_STEP, 0, T_EMPTY, 0);
		send_request(ACT_READ, 3 * GridW + 4, T_EMPTY, 0);
		send_request(ACT_READ, 0, T_EMPTY, 0);
		wait_for_results();
	endtask

	// Mostly a busy corner of the grid, so that flows and lava contacts happen.
	task automatic test_random(int count);
		int n, pick, idx, mass;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				idx = $urandom_range(0, Cells - 1);
			else
				idx = $urandom_range(0, 7) * GridW + $urandom_range(0, 7);
			mass = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 12000);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_request(ACT_WRITE, idx, cell_kind_t'($urandom_range(0, 3)), mass);
			else if (pick < 96)
				send_request(ACT_READ, idx, cell_kind_t'($urandom_range(0, 3)), mass);
			else if (pick < 98)
				send_request(ACT_NONE, idx, cell_kind_t'($urandom_range(0, 3)), mass);
			else
				send_request(ACT_STEP, idx, cell_kind_t'($urandom_range(0, 3)), mass);
		end
		wait_for_results();
	endtask

	// Register settings in phases, extremes included.
	task automatic test_config_phases();
		set_all_cfg(0, 0, 0);
		test_random(300);
		set_all_cfg(65535, 65535, 65535);
		test_random(250);
		set_all_cfg(1, 0, 65535);
		test_random(300);
		set_all_cfg($urandom_range(0, 600), $urandom_range(0, 8192),
			$urandom_range(0, 40000));
		test_random(300);
		set_all_cfg(4, 4096, 32768);
	endtask

	// Results held back while reads keep coming, so the block stalls its input.
	task automatic test_back_pressure();
		int n;
		long_hold = 1'b1;
		for (n = 0; n < 40; n++)
			send_request(ACT_READ, $urandom_range(0, Cells - 1), T_EMPTY, 0);
		wait_for_results();
	endtask

	// Last stretch at full rate on both sides.
	task automatic test_full_rate();
		gaps_on = 1'b0;
		test_random(300);
	endtask

	initial begin
		errors = 0;
		gaps_on = 1'b1;
		long_hold = 1'b0;
		quiet_cycles = 0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		for (int i = 0; i < Cells; i++) begin
			grid_kind[i] = T_EMPTY;
			grid_mass[i] = 0;
		end
		min_liquid_q = 4;
		flow_knee_q = 4096;
		max_speed_q = 32768;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_config_phases();
		test_full_rate();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_liquid_cell_grid_step: done, clean");
		else
			$display("tb_liquid_cell_grid_step: done, errors");
		$finish;
	end

endmodule
